// ===== design/conserved_to_velocity_viscosity_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CONSERVED_TO_VELOCITY_VISCOSITY_DEFINES_SVH
`define CONSERVED_TO_VELOCITY_VISCOSITY_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CVV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CVV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cvv_pkg.sv =====
// Shared constants and types of the velocity and viscosity block.
package cvv_pkg;

   localparam int LAT     = 34;
   localparam int VEL_QB  = 32;
   localparam int T_QB    = 16;
   localparam int VIS_END = 22;

   localparam logic [16:0] ONE_Q = 17'd65536;

   localparam logic [1:0] REG_LEVEL_UPPER = 2'd0;
   localparam logic [1:0] REG_LEVEL_LOWER = 2'd1;
   localparam logic [1:0] REG_VISC_FIRST  = 2'd2;
   localparam logic [1:0] REG_VISC_SECOND = 2'd3;

   localparam logic [31:0] UPPER_RESET = 32'd65536;

   typedef struct packed {
      logic signed [31:0] level_upper;
      logic signed [31:0] level_lower;
      logic [30:0]        visc_first;
      logic [30:0]        visc_second;
   } cfg_type;

endpackage

// ===== design/cvv_vel_div.sv =====
// Pipelined restoring divider for one saturated velocity component.
module cvv_vel_div (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [31:0] mom,
   input  logic [30:0]        dens,
   output logic signed [31:0] vel
);

   localparam int QB = cvv_pkg::VEL_QB;

   logic [31:0] mag_in;
   logic        ovf_in;

   logic [30:0] rem_ff [0:QB];
   logic [31:0] num_ff [0:QB];
   logic [31:0] quo_ff [0:QB];
   logic [30:0] dvs_ff [0:QB];
   logic        neg_ff [0:QB];
   logic        ovf_ff [0:QB];
   logic        mz_ff  [0:QB];

   logic [30:0] rem_in [1:QB];
   logic [31:0] quo_in [1:QB];

   logic [31:0] vel_ff;
   logic [31:0] vel_in;

   assign mag_in = mom[31] ? (~$unsigned(mom) + 32'd1) : $unsigned(mom);
   assign ovf_in = {16'd0, mag_in} >= {1'b0, dens, 16'd0};

   always_comb begin
      logic [31:0] part;
      logic [32:0] dif;
      for (int k = 1; k <= QB; k++) begin
         part = {rem_ff[k-1], num_ff[k-1][31]};
         dif  = {1'b0, part} - {2'b00, dvs_ff[k-1]};
         rem_in[k] = dif[32] ? part[30:0] : dif[30:0];
         quo_in[k] = {quo_ff[k-1][30:0], ~dif[32]};
      end
   end

   always_comb begin
      logic [31:0] q;
      q = quo_ff[QB];
      if (mz_ff[QB]) begin
         vel_in = 32'd0;
      end else if (!neg_ff[QB]) begin
         vel_in = (ovf_ff[QB] || q[31]) ? 32'h7FFF_FFFF : q;
      end else begin
         vel_in = (ovf_ff[QB] || q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= {15'd0, mag_in[31:16]};
         num_ff[0] <= {mag_in[15:0], 16'd0};
         quo_ff[0] <= 32'd0;
         dvs_ff[0] <= dens;
         neg_ff[0] <= mom[31];
         ovf_ff[0] <= ovf_in;
         mz_ff[0]  <= (mag_in == 32'd0);
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= {num_ff[k-1][30:0], 1'b0};
            quo_ff[k] <= quo_in[k];
            dvs_ff[k] <= dvs_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            mz_ff[k]  <= mz_ff[k-1];
         end
         vel_ff <= vel_in;
      end
   end

   assign vel = $signed(vel_ff);

endmodule

// ===== design/cvv_visc.sv =====
// Blend-weight divider and viscosity multiply pipeline.
module cvv_visc (
   input  logic               clock,
   input  logic               adv,
   input  cvv_pkg::cfg_type   cfg,
   input  logic [30:0]        dens,
   input  logic signed [31:0] level_set,
   output logic [30:0]        dyn
);

   localparam int QB  = cvv_pkg::T_QB;
   localparam int PAD = cvv_pkg::LAT - 1 - cvv_pkg::VIS_END;
   localparam int DL  = QB + 4;

   logic [32:0] diff0_ff, den0_ff;
   logic [30:0] dens_ff [0:DL];

   logic        fix_in;
   logic [16:0] tfix_in;
   logic [32:0] adiff_in, aden_in;

   logic [32:0] rem_ff  [1:QB+1];
   logic [32:0] dvs_ff  [1:QB+1];
   logic [15:0] quo_ff  [1:QB+1];
   logic        fix_ff  [1:QB+1];
   logic [16:0] tfix_ff [1:QB+1];
   logic [32:0] rem_in  [2:QB+1];
   logic [15:0] quo_in  [2:QB+1];

   logic [16:0]        t_ff;
   logic signed [49:0] prod_ff, prod_in;
   logic [30:0]        blend_ff, blend_in;
   logic [61:0]        mu_ff;
   logic [30:0]        sat_ff, sat_in;
   logic [30:0]        pad_ff [0:PAD-1];

   always_comb begin
      adiff_in = diff0_ff[32] ? (~diff0_ff + 33'd1) : diff0_ff;
      aden_in  = den0_ff[32] ? (~den0_ff + 33'd1) : den0_ff;
      fix_in   = 1'b1;
      tfix_in  = 17'd0;
      if (den0_ff == 33'd0) begin
         if (diff0_ff[32]) begin
            tfix_in = 17'd0;
         end else if (diff0_ff > {16'd0, cvv_pkg::ONE_Q}) begin
            tfix_in = cvv_pkg::ONE_Q;
         end else begin
            tfix_in = diff0_ff[16:0];
         end
      end else if (diff0_ff == 33'd0 || diff0_ff[32] != den0_ff[32]) begin
         tfix_in = 17'd0;
      end else if (adiff_in >= aden_in) begin
         tfix_in = cvv_pkg::ONE_Q;
      end else begin
         fix_in = 1'b0;
      end
   end

   always_comb begin
      logic [33:0] part;
      logic [34:0] dif;
      for (int k = 2; k <= QB + 1; k++) begin
         part = {rem_ff[k-1], 1'b0};
         dif  = {1'b0, part} - {2'b00, dvs_ff[k-1]};
         rem_in[k] = dif[34] ? part[32:0] : dif[32:0];
         quo_in[k] = {quo_ff[k-1][14:0], ~dif[34]};
      end
   end

   always_comb begin
      logic signed [31:0] dnu;
      logic signed [33:0] sum;
      dnu      = $signed({1'b0, cfg.visc_first}) - $signed({1'b0, cfg.visc_second});
      prod_in  = dnu * $signed({1'b0, t_ff});
      sum      = $signed({3'b000, cfg.visc_second}) + 34'(prod_ff >>> 16);
      blend_in = sum[30:0];
      sat_in   = (|mu_ff[61:47]) ? 31'h7FFF_FFFF : mu_ff[46:16];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff0_ff   <= $signed({level_set[31], level_set})
                       - $signed({cfg.level_lower[31], cfg.level_lower});
         den0_ff    <= $signed({cfg.level_upper[31], cfg.level_upper})
                       - $signed({cfg.level_lower[31], cfg.level_lower});
         dens_ff[0] <= dens;
         for (int k = 1; k <= DL; k++) begin
            dens_ff[k] <= dens_ff[k-1];
         end
         rem_ff[1]  <= adiff_in;
         dvs_ff[1]  <= aden_in;
         quo_ff[1]  <= 16'd0;
         fix_ff[1]  <= fix_in;
         tfix_ff[1] <= tfix_in;
         for (int k = 2; k <= QB + 1; k++) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            dvs_ff[k]  <= dvs_ff[k-1];
            fix_ff[k]  <= fix_ff[k-1];
            tfix_ff[k] <= tfix_ff[k-1];
         end
         t_ff      <= fix_ff[QB+1] ? tfix_ff[QB+1] : {1'b0, quo_ff[QB+1]};
         prod_ff   <= prod_in;
         blend_ff  <= blend_in;
         mu_ff     <= dens_ff[DL] * blend_ff;
         sat_ff    <= sat_in;
         pad_ff[0] <= sat_ff;
         for (int k = 1; k < PAD; k++) begin
            pad_ff[k] <= pad_ff[k-1];
         end
      end
   end

   assign dyn = pad_ff[PAD-1];

endmodule

// ===== design/conserved_to_velocity_viscosity.sv =====
// Top level: conserved variables to velocity and dynamic viscosity.
//
//  channel  | direction | handshake           | payload
//  req      | in        | tvalid/tready       | density, mom_x/y/z, level_set
//  rsp      | out       | tvalid/tready       | vel_x/y/z, dyn_viscosity; tuser div_fault
//  csr      | in        | APB, pready high    | level_upper/lower, visc_first/second
//
// One item per cycle sustained while the output is not stalled; depth set by the 32-stage velocity divider.
// All stages advance together whenever the output stage is empty or taken.
// A stalled output holds every stage and drops req_tready; nothing is lost.
// Reset clears the stage valids and loads the register defaults.
module conserved_to_velocity_viscosity (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // density[30:0], mom_x[62:31], mom_y[94:63], mom_z[126:95], level_set[158:127]
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vel_x[31:0], vel_y[63:32], vel_z[95:64], dyn_viscosity[126:96]
   output logic [127:0] rsp_tdata,
   // div_fault[0]
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int LAT = cvv_pkg::LAT;

   cvv_pkg::cfg_type cfg_ff;
   logic             vld_ff [0:LAT-1];
   logic             flt_ff [0:LAT-1];
   logic             adv;
   logic             wr_en;

   logic [30:0]        dens;
   logic signed [31:0] vel_x, vel_y, vel_z;
   logic [30:0]        dyn;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign dens       = req_tdata[30:0];

   always_comb begin
      case (csr_paddr[3:2])
         cvv_pkg::REG_LEVEL_UPPER: csr_prdata = cfg_ff.level_upper;
         cvv_pkg::REG_LEVEL_LOWER: csr_prdata = cfg_ff.level_lower;
         cvv_pkg::REG_VISC_FIRST:  csr_prdata = {1'b0, cfg_ff.visc_first};
         cvv_pkg::REG_VISC_SECOND: csr_prdata = {1'b0, cfg_ff.visc_second};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_upper <= cvv_pkg::UPPER_RESET;
         cfg_ff.level_lower <= 32'd0;
         cfg_ff.visc_first  <= 31'd0;
         cfg_ff.visc_second <= 31'd0;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            cvv_pkg::REG_LEVEL_UPPER: cfg_ff.level_upper <= csr_pwdata;
            cvv_pkg::REG_LEVEL_LOWER: cfg_ff.level_lower <= csr_pwdata;
            cvv_pkg::REG_VISC_FIRST:  cfg_ff.visc_first  <= csr_pwdata[30:0];
            cvv_pkg::REG_VISC_SECOND: cfg_ff.visc_second <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flt_ff[0] <= (dens == 31'd0);
         for (int k = 1; k < LAT; k++) begin
            flt_ff[k] <= flt_ff[k-1];
         end
      end
   end

   cvv_vel_div u_div_x (.clock(clock), .adv(adv), .mom($signed(req_tdata[62:31])),
                        .dens(dens), .vel(vel_x));
   cvv_vel_div u_div_y (.clock(clock), .adv(adv), .mom($signed(req_tdata[94:63])),
                        .dens(dens), .vel(vel_y));
   cvv_vel_div u_div_z (.clock(clock), .adv(adv), .mom($signed(req_tdata[126:95])),
                        .dens(dens), .vel(vel_z));

   cvv_visc u_visc (
      .clock(clock),
      .adv(adv),
      .cfg(cfg_ff),
      .dens(dens),
      .level_set($signed(req_tdata[158:127])),
      .dyn(dyn)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {1'b0, dyn, vel_z, vel_y, vel_x};
   assign rsp_tuser  = flt_ff[LAT-1];

endmodule

// ===== design/cvv_checker.sv =====
// Port-level checker for the velocity and viscosity block, with its bind.
`include "conserved_to_velocity_viscosity_defines.svh"

module cvv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);

   `CVV_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled transfer changed")
   `CVV_ASSERT_NOW(a_ready, 1'b1, req_tready == (!rsp_tvalid || rsp_tready), "ready not tied to output stage")
   `CVV_ASSERT_NOW(a_fault_dyn, rsp_tvalid && rsp_tuser, rsp_tdata[126:96] == 31'd0, "fault with nonzero viscosity")
   `CVV_ASSERT_NOW(a_fault_vel, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == 32'd0 || rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000, "fault velocity not saturated")

endmodule

bind conserved_to_velocity_viscosity cvv_checker u_cvv_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the conserved-to-velocity and viscosity block.
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic [30:0] dyn_visc;
      logic        fault;
   } point_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // density, mom_x, mom_y, mom_z, level_set (lowest bit first)
   logic [159:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // vel_x, vel_y, vel_z, dyn_viscosity (lowest bit first)
   logic [127:0] rsp_tdata;
   // div_fault
   logic         rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic signed [31:0] cfg_upper;
   logic signed [31:0] cfg_lower;
   logic [30:0]        cfg_nu1;
   logic [30:0]        cfg_nu2;

   point_result_type pending_results[$];
   int  mismatches;
   int  results_seen;
   int  points_sent;
   int  faults_seen;
   bit  idle_enable;

   conserved_to_velocity_viscosity dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [31:0] divide_velocity(logic signed [31:0] mom,
                                                   logic [30:0] dens);
      longint q;
      if (dens == 0) begin
         if (mom > 0) q = 64'sd2147483647;
         else if (mom < 0) q = -64'sd2147483648;
         else q = 0;
      end else begin
         q = (longint'(mom) * 65536) / longint'(dens);
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      return q[31:0];
   endfunction

   function automatic point_result_type convert_point(logic [159:0] item);
      point_result_type r;
      logic [30:0] dens;
      longint diff, span, t, blend, mu;
      dens = item[30:0];
      diff = longint'($signed(item[158:127])) - longint'(cfg_lower);
      span = longint'(cfg_upper) - longint'(cfg_lower);
      if (span == 0) t = diff;
      else t = (diff * 65536) / span;
      if (t < 0) t = 0;
      if (t > 65536) t = 65536;
      blend = (longint'(cfg_nu2) * (65536 - t) + longint'(cfg_nu1) * t) >>> 16;
      mu = (longint'(dens) * blend) >>> 16;
      if (mu > 64'sd2147483647) mu = 64'sd2147483647;
      r.vel_x = divide_velocity($signed(item[62:31]), dens);
      r.vel_y = divide_velocity($signed(item[94:63]), dens);
      r.vel_z = divide_velocity($signed(item[126:95]), dens);
      r.dyn_visc = mu[30:0];
      r.fault = (dens == 0);
      return r;
   endfunction

   task automatic idle_burst();
      repeat ($urandom_range(1, 8)) @(negedge clock);
   endtask

   task automatic send_point(logic [30:0] dens, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] mz, logic [31:0] g);
      logic [159:0] item;
      item = {1'b0, g, mz, my, mx, dens};
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         idle_burst();
      end
      req_tdata  <= item;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(convert_point(item));
      points_sent++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (cvv_pkg::LAT + 4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         cvv_pkg::REG_LEVEL_UPPER: cfg_upper = value;
         cvv_pkg::REG_LEVEL_LOWER: cfg_lower = value;
         cvv_pkg::REG_VISC_FIRST:  cfg_nu1 = value[30:0];
         default:                  cfg_nu2 = value[30:0];
      endcase
   endtask

   task automatic set_config(logic [31:0] up, logic [31:0] lo, logic [31:0] n1,
                             logic [31:0] n2);
      write_reg(cvv_pkg::REG_LEVEL_UPPER, up);
      write_reg(cvv_pkg::REG_LEVEL_LOWER, lo);
      write_reg(cvv_pkg::REG_VISC_FIRST, n1);
      write_reg(cvv_pkg::REG_VISC_SECOND, n2);
   endtask

   function automatic logic [31:0] rand_level();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return cfg_lower + $urandom_range(0, 2) - 1;
         2:       return cfg_upper + $urandom_range(0, 2) - 1;
         default: return cfg_lower + ((cfg_upper - cfg_lower) / 1024) * $urandom_range(0, 1100);
      endcase
   endfunction

   function automatic logic [30:0] rand_density();
      case ($urandom_range(0, 7))
         0:       return 31'd0;
         1:       return 31'($urandom_range(1, 4));
         2:       return 31'h7fffffff;
         3:       return 31'($urandom_range(32768, 131072));
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic send_random_points(int count);
      repeat (count)
         send_point(rand_density(), $urandom, $urandom, $urandom, rand_level());
   endtask

   task automatic test_directed_extremes();
      send_point(31'd0, 32'd5, 32'hffff_fff0, 32'd0, 32'd0);
      send_point(31'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'h8000_0000);
      send_point(31'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
      send_point(31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd65536, 32'd32768);
      send_point(31'd65536, 32'd65536, 32'hffff_0000, 32'd0, 32'd65536);
      send_point(31'd65536, 32'd1, 32'hffff_ffff, 32'd3, 32'hffff_ffff);
      send_point(31'd3, 32'd7, 32'hffff_fff9, 32'd10, 32'd16384);
      send_point(31'h4000_0000, 32'h1234_5678, 32'h8765_4321, 32'd0, 32'd70000);
      end_burst();
   endtask

   task automatic test_equal_levels();
      set_config(32'd1000, 32'd1000, 32'h7fff_ffff, 32'd12345);
      send_point(31'd65536, 32'd1, 32'd2, 32'd3, 32'd1000);
      send_point(31'd65536, 32'd1, 32'd2, 32'd3, 32'd999);
      send_point(31'd65536, 32'd1, 32'd2, 32'd3, 32'd40000);
      send_point(31'h7fff_ffff, 32'd1, 32'd2, 32'd3, 32'd200000);
      send_point(31'h7fff_ffff, 32'd1, 32'd2, 32'd3, 32'h8000_0000);
      end_burst();
   endtask

   task automatic test_config_extremes();
      set_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_random_points(150);
      end_burst();
      set_config(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'h7fff_ffff);
      send_random_points(150);
      end_burst();
      set_config(32'hffff_0000, 32'd0, 32'd65536, 32'd0);
      send_random_points(150);
      end_burst();
   endtask

   task automatic test_random_sweep();
      repeat (6) begin
         set_config($urandom, $urandom, $urandom, $urandom);
         send_random_points(150);
         end_burst();
      end
      set_config(32'd65536, 32'd0, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
      send_random_points(150);
      end_burst();
   endtask

   task automatic test_full_rate();
      idle_enable = 1'b0;
      set_config(32'd131072, 32'hffff_0000, $urandom, $urandom);
      send_random_points(200);
      end_burst();
   endtask

   always @(posedge clock) begin
      point_result_type want;
      point_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got.vel_x    = rsp_tdata[31:0];
         got.vel_y    = rsp_tdata[63:32];
         got.vel_z    = rsp_tdata[95:64];
         got.dyn_visc = rsp_tdata[126:96];
         got.fault    = rsp_tuser;
         if (got.fault) faults_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer on rsp at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: vel %h %h %h visc %h fault %b, expected %h %h %h %h %b",
                           got.vel_x, got.vel_y, got.vel_z, got.dyn_visc, got.fault,
                           want.vel_x, want.vel_y, want.vel_z, want.dyn_visc, want.fault);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (idle_enable && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         idle_burst();
      end
      rsp_tready <= 1'b1;
   end

   initial begin
      #5_000_000;
      $display("conserved_to_velocity_viscosity regression: fail");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_upper   = cvv_pkg::UPPER_RESET;
      cfg_lower   = 0;
      cfg_nu1     = 0;
      cfg_nu2     = 0;
      mismatches  = 0;
      results_seen = 0;
      points_sent = 0;
      faults_seen = 0;
      idle_enable = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_equal_levels();
      test_config_extremes();
      test_random_sweep();
      test_full_rate();
      $display("sent %0d grid points, checked %0d results, %0d with zero density",
               points_sent, results_seen, faults_seen);
      $display("covered reset and extreme level/viscosity settings, equal levels, stalls");
      if (mismatches == 0 && pending_results.size() == 0)
         $display("conserved_to_velocity_viscosity regression: pass");
      else
         $display("conserved_to_velocity_viscosity regression: fail");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+design
design/cvv_pkg.sv
design/cvv_vel_div.sv
design/cvv_visc.sv
design/conserved_to_velocity_viscosity.sv
design/cvv_checker.sv
test/testbench.sv
